// File: src/bbl_pkg.sv
// Package for the byte-budget LRU cache with pins.
// Holds operation kinds, result status codes, sequencer states and byte helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbl_pkg;

  localparam int TOTAL_W = 40;
  localparam int KEY_W   = 32;
  localparam int SIZE_W  = 32;
  localparam int STAMP_W = 64;
  localparam int EV_W    = 5;

  typedef enum logic [2:0] {
    K_LOOKUP = 3'd0,
    K_ADMIT  = 3'd1,
    K_PIN    = 3'd2,
    K_UNPIN  = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    STS_DONE    = 3'd0,
    STS_MISS    = 3'd1,
    STS_HIT     = 3'd2,
    STS_NOROOM  = 3'd3,
    STS_NOOBJ   = 3'd4,
    STS_PINFULL = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_SCAN,
    S_AD_PIN,
    S_AD_DROP,
    S_AD_FIT,
    S_AD_EVSCAN,
    S_AD_EVICT,
    S_AD_INS,
    S_PN_SCAN,
    S_PN_NEW,
    S_UP_SCAN,
    S_SWEEP,
    S_DONE
  } state_t;

  // Subtract a size from the byte total, stopping at zero
  function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
    logic [TOTAL_W-1:0] bx;
    bx = {{(TOTAL_W-SIZE_W){1'b0}}, b};
    return (a >= bx) ? a - bx : '0;
  endfunction

endpackage

`default_nettype wire

// File: src/bbl_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the entry table and the pin table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                   wdata,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                   rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/bbl_ctrl.sv
// Sequencer for the byte-budget LRU cache: scans the entry and pin RAMs,
// keeps valid/pin bitmaps, byte totals and the output register. Uses bbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbl_ctrl #(
  parameter int RESIDENT_ENTRIES = 16,
  parameter int PIN_ENTRIES      = 16,
  parameter int PIN_COUNT_MAX    = 255,
  localparam int EAW = $clog2(RESIDENT_ENTRIES),
  localparam int PAW = (PIN_ENTRIES > 1) ? $clog2(PIN_ENTRIES) : 1,
  localparam int CW  = $clog2(PIN_COUNT_MAX + 1),
  localparam int EWD = 128,
  localparam int PWD = 32 + CW
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [39:0]                 budget,
  // input transaction
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_kind,
  input  wire logic [31:0]                 in_key,
  input  wire logic [31:0]                 in_bytes,
  input  wire logic                        in_present,
  // result transaction
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       out_status,
  output logic [4:0]                       out_evicted,
  output logic [39:0]                      out_total,
  output logic [39:0]                      out_peak,
  // entry RAM
  output logic                             ent_we,
  output logic [EAW-1:0]                   ent_wa,
  output logic [EWD-1:0]                   ent_wd,
  output logic [EAW-1:0]                   ent_ra,
  input  wire logic [EWD-1:0]              ent_rd,
  // pin RAM
  output logic                             pin_we,
  output logic [PAW-1:0]                   pin_wa,
  output logic [PWD-1:0]                   pin_wd,
  output logic [PAW-1:0]                   pin_ra,
  input  wire logic [PWD-1:0]              pin_rd
);
  import bbl_pkg::*;

  localparam int SW = ((EAW > PAW) ? EAW : PAW) + 1;
  localparam logic [SW-1:0] ELIM = SW'(RESIDENT_ENTRIES);
  localparam logic [SW-1:0] PLIM = SW'(PIN_ENTRIES);
  localparam logic [CW-1:0] PMAX = CW'(PIN_COUNT_MAX);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  // control state
  state_t                 st_r, st_nxt;
  logic [SW-1:0]          sc_r, sc_nxt;
  logic                   dv_r, dv_nxt;
  logic [RESIDENT_ENTRIES-1:0] ent_vld_r, ent_vld_nxt;
  logic [PIN_ENTRIES-1:0] pin_vld_r, pin_vld_nxt;
  logic [STAMP_W-1:0]     touch_r, touch_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [TOTAL_W-1:0]     peak_r, peak_nxt;
  logic                   out_vld_r, out_vld_nxt;

  // payload state
  logic [SW-2:0]          dix_r, dix_nxt;
  logic [RESIDENT_ENTRIES-1:0] ent_pin_r, ent_pin_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [SIZE_W-1:0]      inc_r, inc_nxt;
  logic [EV_W-1:0]        ev_r, ev_nxt;
  status_t                status_r, status_nxt;
  logic                   free_ok_r, free_ok_nxt;
  logic [EAW-1:0]         free_ix_r, free_ix_nxt;
  logic                   pinflag_r, pinflag_nxt;
  logic                   best_ok_r, best_ok_nxt;
  logic [EAW-1:0]         best_ix_r, best_ix_nxt;
  logic [STAMP_W-1:0]     best_st_r, best_st_nxt;
  logic [SIZE_W-1:0]      best_sz_r, best_sz_nxt;
  logic                   pfree_ok_r, pfree_ok_nxt;
  logic [PAW-1:0]         pfree_ix_r, pfree_ix_nxt;
  logic                   sweep_set_r, sweep_set_nxt;
  status_t                ostat_r, ostat_nxt;
  logic [EV_W-1:0]        oev_r, oev_nxt;
  logic [TOTAL_W-1:0]     otot_r, otot_nxt;
  logic [TOTAL_W-1:0]     opeak_r, opeak_nxt;

  // shared decode
  logic                   in_fire, out_free;
  logic [EAW-1:0]         e_ix;
  logic [PAW-1:0]         p_ix;
  logic [KEY_W-1:0]       e_key, p_key;
  logic [SIZE_W-1:0]      e_size;
  logic [STAMP_W-1:0]     e_stamp;
  logic [CW-1:0]          p_cnt;
  logic                   e_match, p_match;
  logic                   e_scan, p_scan;
  logic [SW-1:0]          lim;
  logic                   issue, scan_end;
  logic [TOTAL_W-1:0]     inc40;
  logic                   fits;
  logic [TOTAL_W-1:0]     sum40;

  assign in_ready = (st_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_vld_r || out_ready;

  assign e_ix    = dix_r[EAW-1:0];
  assign p_ix    = dix_r[PAW-1:0];
  assign e_key   = ent_rd[31:0];
  assign e_size  = ent_rd[63:32];
  assign e_stamp = ent_rd[127:64];
  assign p_key   = pin_rd[31:0];
  assign p_cnt   = pin_rd[32 +: CW];
  assign e_match = dv_r && ent_vld_r[e_ix] && (e_key == key_r);
  assign p_match = dv_r && pin_vld_r[p_ix] && (p_key == key_r);

  assign e_scan = (st_r == S_LK_SCAN) || (st_r == S_AD_DROP) ||
                  (st_r == S_AD_EVSCAN) || (st_r == S_SWEEP);
  assign p_scan = (st_r == S_AD_PIN) || (st_r == S_PN_SCAN) || (st_r == S_UP_SCAN);
  assign lim      = e_scan ? ELIM : PLIM;
  assign issue    = (e_scan || p_scan) && (sc_r < lim);
  assign scan_end = (sc_r >= lim) && !dv_r;

  assign ent_ra = sc_r[EAW-1:0];
  assign pin_ra = sc_r[PAW-1:0];

  // Budget check: the new object fits beside the current total
  assign inc40 = {{(TOTAL_W-SIZE_W){1'b0}}, inc_r};
  assign fits  = (inc_r == '0) || ((inc40 <= budget) && (total_r <= budget - inc40));
  assign sum40 = total_r + inc40;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          case (kind_t'(in_kind))
            K_LOOKUP: st_nxt = S_LK_SCAN;
            K_ADMIT:  st_nxt = in_present ? S_AD_PIN : S_DONE;
            K_PIN:    st_nxt = S_PN_SCAN;
            K_UNPIN:  st_nxt = S_UP_SCAN;
            default:  st_nxt = S_DONE;
          endcase
        end
      end
      S_LK_SCAN: begin
        if (e_match || scan_end) st_nxt = S_DONE;
      end
      S_AD_PIN: begin
        if (p_match || scan_end) st_nxt = S_AD_DROP;
      end
      S_AD_DROP: begin
        if (scan_end) st_nxt = S_AD_FIT;
      end
      S_AD_FIT: begin
        st_nxt = (fits && free_ok_r) ? S_AD_INS : S_AD_EVSCAN;
      end
      S_AD_EVSCAN: begin
        if (scan_end) st_nxt = S_AD_EVICT;
      end
      S_AD_EVICT: begin
        st_nxt = best_ok_r ? S_AD_FIT : S_DONE;
      end
      S_AD_INS: st_nxt = S_DONE;
      S_PN_SCAN: begin
        if (p_match) st_nxt = S_DONE;
        else if (scan_end) st_nxt = pfree_ok_r ? S_PN_NEW : S_DONE;
      end
      S_PN_NEW: st_nxt = S_SWEEP;
      S_UP_SCAN: begin
        if (p_match) st_nxt = (p_cnt <= CNT_ONE) ? S_SWEEP : S_DONE;
        else if (scan_end) st_nxt = S_DONE;
      end
      S_SWEEP: begin
        if (scan_end) st_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    sc_nxt        = sc_r;
    dv_nxt        = dv_r;
    dix_nxt       = dix_r;
    ent_vld_nxt   = ent_vld_r;
    ent_pin_nxt   = ent_pin_r;
    pin_vld_nxt   = pin_vld_r;
    touch_nxt     = touch_r;
    total_nxt     = total_r;
    peak_nxt      = peak_r;
    out_vld_nxt   = out_vld_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    inc_nxt       = inc_r;
    ev_nxt        = ev_r;
    status_nxt    = status_r;
    free_ok_nxt   = free_ok_r;
    free_ix_nxt   = free_ix_r;
    pinflag_nxt   = pinflag_r;
    best_ok_nxt   = best_ok_r;
    best_ix_nxt   = best_ix_r;
    best_st_nxt   = best_st_r;
    best_sz_nxt   = best_sz_r;
    pfree_ok_nxt  = pfree_ok_r;
    pfree_ix_nxt  = pfree_ix_r;
    sweep_set_nxt = sweep_set_r;
    ostat_nxt     = ostat_r;
    oev_nxt       = oev_r;
    otot_nxt      = otot_r;
    opeak_nxt     = opeak_r;
    ent_we        = 1'b0;
    ent_wa        = e_ix;
    ent_wd        = {touch_r + 64'd1, ent_rd[63:0]};
    pin_we        = 1'b0;
    pin_wa        = p_ix;
    pin_wd        = {p_cnt + CNT_ONE, key_r};

    // Drop the accepted result once the receiver takes it
    if (out_vld_r && out_ready) out_vld_nxt = 1'b0;

    // Advance the scan pointer; restart it on every state change
    if (st_nxt != st_r) begin
      sc_nxt = '0;
      dv_nxt = 1'b0;
    end else begin
      dv_nxt  = issue;
      dix_nxt = sc_r[SW-2:0];
      if (issue) sc_nxt = sc_r + 1'b1;
    end

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt     = kind_t'(in_kind);
          key_nxt      = in_key;
          inc_nxt      = in_bytes;
          ev_nxt       = '0;
          status_nxt   = STS_DONE;
          free_ok_nxt  = 1'b0;
          pinflag_nxt  = 1'b0;
          pfree_ok_nxt = 1'b0;
          case (kind_t'(in_kind))
            K_LOOKUP: status_nxt = STS_MISS;
            K_ADMIT: begin
              if (!in_present) status_nxt = STS_NOOBJ;
            end
            K_CLEAR: begin
              ent_vld_nxt = '0;
              ent_pin_nxt = '0;
              pin_vld_nxt = '0;
              total_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      // Refresh the stamp of the first matching entry
      S_LK_SCAN: begin
        if (e_match) begin
          ent_we     = 1'b1;
          touch_nxt  = touch_r + 64'd1;
          status_nxt = STS_HIT;
        end
      end
      S_AD_PIN: begin
        if (p_match) pinflag_nxt = 1'b1;
      end
      // Drop a resident copy of the key and note the first free slot
      S_AD_DROP: begin
        if (dv_r) begin
          if (e_match) begin
            ent_vld_nxt[e_ix] = 1'b0;
            total_nxt         = sat_sub(total_r, e_size);
          end
          if ((!ent_vld_r[e_ix] || e_match) && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_ix_nxt = e_ix;
          end
        end
      end
      S_AD_FIT: begin
        best_ok_nxt = 1'b0;
      end
      // Track the oldest unpinned entry, lowest index on a tie
      S_AD_EVSCAN: begin
        if (dv_r && ent_vld_r[e_ix] && !ent_pin_r[e_ix] &&
            (!best_ok_r || (e_stamp < best_st_r))) begin
          best_ok_nxt = 1'b1;
          best_ix_nxt = e_ix;
          best_st_nxt = e_stamp;
          best_sz_nxt = e_size;
        end
      end
      S_AD_EVICT: begin
        if (best_ok_r) begin
          ent_vld_nxt[best_ix_r] = 1'b0;
          total_nxt              = sat_sub(total_r, best_sz_r);
          ev_nxt                 = ev_r + 1'b1;
          if (!free_ok_r || (best_ix_r < free_ix_r)) begin
            free_ok_nxt = 1'b1;
            free_ix_nxt = best_ix_r;
          end
        end else begin
          status_nxt = STS_NOROOM;
        end
      end
      // Write the new entry into the free slot
      S_AD_INS: begin
        ent_we                 = 1'b1;
        ent_wa                 = free_ix_r;
        ent_wd                 = {touch_r + 64'd1, inc_r, key_r};
        touch_nxt              = touch_r + 64'd1;
        ent_vld_nxt[free_ix_r] = 1'b1;
        ent_pin_nxt[free_ix_r] = pinflag_r;
        total_nxt              = sum40;
        if (sum40 > peak_r) peak_nxt = sum40;
      end
      S_PN_SCAN: begin
        if (p_match) begin
          pin_we = (p_cnt < PMAX);
        end else if (dv_r && !pin_vld_r[p_ix] && !pfree_ok_r) begin
          pfree_ok_nxt = 1'b1;
          pfree_ix_nxt = p_ix;
        end
        if (!p_match && scan_end && !pfree_ok_r) status_nxt = STS_PINFULL;
      end
      S_PN_NEW: begin
        pin_we                  = 1'b1;
        pin_wa                  = pfree_ix_r;
        pin_wd                  = {CNT_ONE, key_r};
        pin_vld_nxt[pfree_ix_r] = 1'b1;
        sweep_set_nxt           = 1'b1;
      end
      S_UP_SCAN: begin
        if (p_match) begin
          if (p_cnt <= CNT_ONE) begin
            pin_vld_nxt[p_ix] = 1'b0;
            sweep_set_nxt     = 1'b0;
          end else begin
            pin_we = 1'b1;
            pin_wd = {p_cnt - CNT_ONE, key_r};
          end
        end
      end
      // Mirror the pin state onto the entry holding the key
      S_SWEEP: begin
        if (dv_r && (e_key == key_r)) ent_pin_nxt[e_ix] = sweep_set_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          ostat_nxt   = status_r;
          oev_nxt     = ev_r;
          otot_nxt    = total_r;
          opeak_nxt   = peak_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      sc_r      <= '0;
      dv_r      <= 1'b0;
      ent_vld_r <= '0;
      pin_vld_r <= '0;
      touch_r   <= '0;
      total_r   <= '0;
      peak_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      sc_r      <= sc_nxt;
      dv_r      <= dv_nxt;
      ent_vld_r <= ent_vld_nxt;
      pin_vld_r <= pin_vld_nxt;
      touch_r   <= touch_nxt;
      total_r   <= total_nxt;
      peak_r    <= peak_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dix_r       <= dix_nxt;
    ent_pin_r   <= ent_pin_nxt;
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    inc_r       <= inc_nxt;
    ev_r        <= ev_nxt;
    status_r    <= status_nxt;
    free_ok_r   <= free_ok_nxt;
    free_ix_r   <= free_ix_nxt;
    pinflag_r   <= pinflag_nxt;
    best_ok_r   <= best_ok_nxt;
    best_ix_r   <= best_ix_nxt;
    best_st_r   <= best_st_nxt;
    best_sz_r   <= best_sz_nxt;
    pfree_ok_r  <= pfree_ok_nxt;
    pfree_ix_r  <= pfree_ix_nxt;
    sweep_set_r <= sweep_set_nxt;
    ostat_r     <= ostat_nxt;
    oev_r       <= oev_nxt;
    otot_r      <= otot_nxt;
    opeak_r     <= opeak_nxt;
  end

  assign out_valid   = out_vld_r;
  assign out_status  = ostat_r;
  assign out_evicted = oev_r;
  assign out_total   = otot_r;
  assign out_peak    = opeak_r;

`ifndef SYNTH
  a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= peak_r) else $error("resident total above peak");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> peak_r >= $past(peak_r)) else $error("peak decreased");

  a_touch_step: assert property (@(posedge clk) disable iff (!rst_n)
    (touch_r != $past(touch_r)) |-> (touch_r == $past(touch_r) + 64'd1))
    else $error("touch counter jumped");

  a_pinfull_only_pin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && status_r == STS_PINFULL) |-> (kind_r == K_PIN))
    else $error("pin table full reported for a non-pin transaction");
`endif

endmodule

`default_nettype wire

// File: src/byte_budget_lru_cache_with_pins.sv
// Top level of the byte-budget LRU cache with pins: configuration register,
// entry and pin RAMs, sequencer. Depends on bbl_pkg, bbl_ram, bbl_ctrl.
//
// Usage: an operation enters on the in_ stream (lookup, admit, pin, unpin,
// clear); exactly one result leaves on the out_ stream for each one, carrying
// status, eviction count, resident byte total and peak total.
// The budget register sits at byte address 0 of the cfg_ port (64-bit data).
// Work per operation, with N = RESIDENT_ENTRIES and P = PIN_ENTRIES: clear,
// unused kinds and an admit of a missing object go straight to the result;
// lookup scans up to N entries, pin/unpin up to P (plus a sweep of N when a
// key enters or leaves the pin table), and admit scans P and N entries plus
// a scan of N for every eviction attempt. The cost is set by the
// one-entry-per-cycle read of the entry RAM and pin RAM.
// One operation is worked on at a time; in_tready is high only when idle.
// A finished result waits in the output register while the receiver stalls;
// the next operation may already be accepted and runs until its own result
// needs that register.
// Reset clears the valid bitmaps, totals, touch counter and budget; the entry
// pin bitmap and RAM contents are not cleared, and the RAMs need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_budget_lru_cache_with_pins #(
  parameter int RESIDENT_ENTRIES = 16,
  parameter int PIN_ENTRIES      = 16,
  parameter int PIN_COUNT_MAX    = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // asset_key[31:0], incoming_bytes[63:32], object_present[64]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,
  // kind[2:0]
  input  wire logic [2:0]  in_tuser,
  // status[2:0], evicted_count[7:3], resident_total[47:8], peak_total[87:48]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bbl_pkg::*;

  localparam int EAW = $clog2(RESIDENT_ENTRIES);
  localparam int PAW = (PIN_ENTRIES > 1) ? $clog2(PIN_ENTRIES) : 1;
  localparam int CW  = $clog2(PIN_COUNT_MAX + 1);
  localparam int EWD = 128;
  localparam int PWD = 32 + CW;
  localparam logic [3:0] ADDR_BUDGET = 4'd0;

  logic [TOTAL_W-1:0] budget_r;
  logic               budget_sel;

  logic               ent_we, pin_we;
  logic [EAW-1:0]     ent_wa, ent_ra;
  logic [EWD-1:0]     ent_wd, ent_rd;
  logic [PAW-1:0]     pin_wa, pin_ra;
  logic [PWD-1:0]     pin_wd, pin_rd;

  logic [2:0]         o_status;
  logic [4:0]         o_ev;
  logic [39:0]        o_total, o_peak;

  // Configuration port, register 0 decoded on its 8-byte slot
  assign cfg_pready = 1'b1;
  assign budget_sel = (cfg_paddr[3] == ADDR_BUDGET[3]);
  assign cfg_prdata = budget_sel ? {24'd0, budget_r} : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && budget_sel) begin
      budget_r <= cfg_pwdata[TOTAL_W-1:0];
    end
  end

  bbl_ram #(.W(EWD), .D(RESIDENT_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_wa),
    .wdata (ent_wd),
    .raddr (ent_ra),
    .rdata (ent_rd)
  );

  bbl_ram #(.W(PWD), .D(PIN_ENTRIES)) u_pin_ram (
    .clk   (clk),
    .we    (pin_we),
    .waddr (pin_wa),
    .wdata (pin_wd),
    .raddr (pin_ra),
    .rdata (pin_rd)
  );

  bbl_ctrl #(
    .RESIDENT_ENTRIES (RESIDENT_ENTRIES),
    .PIN_ENTRIES      (PIN_ENTRIES),
    .PIN_COUNT_MAX    (PIN_COUNT_MAX)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .budget      (budget_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_key      (in_tdata[31:0]),
    .in_bytes    (in_tdata[63:32]),
    .in_present  (in_tdata[64]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (o_status),
    .out_evicted (o_ev),
    .out_total   (o_total),
    .out_peak    (o_peak),
    .ent_we      (ent_we),
    .ent_wa      (ent_wa),
    .ent_wd      (ent_wd),
    .ent_ra      (ent_ra),
    .ent_rd      (ent_rd),
    .pin_we      (pin_we),
    .pin_wa      (pin_wa),
    .pin_wd      (pin_wd),
    .pin_ra      (pin_ra),
    .pin_rd      (pin_rd)
  );

  assign out_tdata = {o_peak, o_total, o_ev, o_status};

endmodule

`default_nettype wire

// File: verif/bbl_checker.sv
// Checker for the byte-budget LRU cache with pins: watches the config,
// input and result channels, predicts each result and compares it.
// Depends on bbl_pkg.
`timescale 1ns / 1ps

module bbl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  import bbl_pkg::*;

  localparam int NE = 16;
  localparam int NP = 16;
  localparam int PMAX = 255;
  localparam logic [3:0] ADDR_BUDGET = 4'd0;

  typedef struct packed {
    logic [39:0] peak;
    logic [39:0] total;
    logic [4:0]  evicted;
    logic [2:0]  status;
  } cache_result_t;

  // Predicted cache state
  logic        ent_v [NE];
  logic [31:0] ent_key [NE];
  logic [31:0] ent_size [NE];
  logic [63:0] ent_stamp [NE];
  logic [63:0] touches;
  logic        pin_v [NP];
  logic [31:0] pin_k [NP];
  logic [15:0] pin_n [NP];
  logic [39:0] bytes_now;
  logic [39:0] bytes_peak;
  logic [39:0] budget;

  cache_result_t expected_results[$];

  assign pending = expected_results.size();

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic bit is_pinned(input logic [31:0] key);
    for (int i = 0; i < NP; i++)
      if (pin_v[i] && pin_k[i] == key && pin_n[i] != 0) return 1;
    return 0;
  endfunction

  function automatic void drop_slot(input int i);
    logic [39:0] sz;
    sz = {8'd0, ent_size[i]};
    bytes_now = (bytes_now >= sz) ? bytes_now - sz : '0;
    ent_v[i] = 0;
  endfunction

  function automatic bit evict_lru();
    int best;
    best = -1;
    for (int i = 0; i < NE; i++) begin
      if (!ent_v[i] || is_pinned(ent_key[i])) continue;
      if (best < 0 || ent_stamp[i] < ent_stamp[best]) best = i;
    end
    if (best < 0) return 0;
    drop_slot(best);
    return 1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < NE; i++)
      if (!ent_v[i]) return i;
    return -1;
  endfunction

  function automatic status_t admit(input logic [31:0] key, input logic [31:0] size,
                                    input logic present, inout logic [4:0] ev);
    logic [40:0] inc;
    int slot;
    inc = {9'd0, size};
    if (!present) return STS_NOOBJ;
    for (int i = 0; i < NE; i++)
      if (ent_v[i] && ent_key[i] == key) drop_slot(i);
    if (inc != 0) begin
      while (!(inc <= {1'b0, budget} && {1'b0, bytes_now} <= {1'b0, budget} - inc)) begin
        if (!evict_lru()) return STS_NOROOM;
        ev++;
      end
    end
    slot = free_slot();
    if (slot < 0) begin
      if (!evict_lru()) return STS_NOROOM;
      ev++;
      slot = free_slot();
    end
    touches++;
    ent_v[slot] = 1;
    ent_key[slot] = key;
    ent_size[slot] = size;
    ent_stamp[slot] = touches;
    bytes_now = bytes_now + inc[39:0];
    if (bytes_now > bytes_peak) bytes_peak = bytes_now;
    return STS_DONE;
  endfunction

  function automatic status_t pin(input logic [31:0] key);
    int fs;
    fs = -1;
    for (int i = 0; i < NP; i++) begin
      if (pin_v[i] && pin_k[i] == key) begin
        if (pin_n[i] < PMAX) pin_n[i]++;
        return STS_DONE;
      end
      if (!pin_v[i] && fs < 0) fs = i;
    end
    if (fs < 0) return STS_PINFULL;
    pin_v[fs] = 1;
    pin_k[fs] = key;
    pin_n[fs] = 1;
    return STS_DONE;
  endfunction

  function automatic void unpin(input logic [31:0] key);
    for (int i = 0; i < NP; i++)
      if (pin_v[i] && pin_k[i] == key) begin
        if (pin_n[i] <= 1) pin_v[i] = 0;
        else pin_n[i]--;
        return;
      end
  endfunction

  function automatic cache_result_t predict_result(input logic [2:0] u, input logic [71:0] d);
    cache_result_t r;
    logic [2:0]  kind;
    logic [31:0] key;
    logic [4:0]  ev;
    status_t     st;
    kind = u;
    key = d[31:0];
    ev = '0;
    st = STS_DONE;
    case (kind)
      K_LOOKUP: begin
        st = STS_MISS;
        for (int i = 0; i < NE; i++)
          if (ent_v[i] && ent_key[i] == key) begin
            touches++;
            ent_stamp[i] = touches;
            st = STS_HIT;
            break;
          end
      end
      K_ADMIT: st = admit(key, d[63:32], d[64], ev);
      K_PIN:   st = pin(key);
      K_UNPIN: unpin(key);
      K_CLEAR: begin
        for (int i = 0; i < NE; i++) ent_v[i] = 0;
        for (int i = 0; i < NP; i++) pin_v[i] = 0;
        bytes_now = '0;
      end
      default: ;
    endcase
    r.status = st;
    r.evicted = ev;
    r.total = bytes_now;
    r.peak = bytes_peak;
    return r;
  endfunction

  // Track config writes, predict on input transactions, check results
  always @(posedge clk) begin
    cache_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NE; i++) ent_v[i] = 0;
      for (int i = 0; i < NP; i++) pin_v[i] = 0;
      touches = '0;
      bytes_now = '0;
      bytes_peak = '0;
      budget = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[3] == ADDR_BUDGET[3])
        budget = cfg_pwdata[39:0];
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_result(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          report("unexpected result transaction", got.total, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.evicted !== want.evicted) report("evicted", got.evicted, want.evicted);
          if (got.total !== want.total) report("total", got.total, want.total);
          if (got.peak !== want.peak) report("peak", got.peak, want.peak);
        end
      end
    end
  end
endmodule

// File: verif/tb_byte_budget_lru_cache_with_pins.sv
// Testbench top for the byte-budget LRU cache with pins: drives operations
// and budget writes, instantiates the block and bbl_checker, gives verdict.
// Depends on bbl_pkg, byte_budget_lru_cache_with_pins, bbl_checker.
`timescale 1ns / 1ps

module tb_byte_budget_lru_cache_with_pins;
  import bbl_pkg::*;

  localparam logic [3:0] ADDR_BUDGET = 4'd0;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // asset_key, incoming_bytes, object_present
  logic [2:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // status, evicted_count, resident_total, peak_total
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending;
  logic [31:0] key_pool [8];

  byte_budget_lru_cache_with_pins dut (.*);

  bbl_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #200ms;
    $display("tb_byte_budget_lru_cache_with_pins NOT OK");
    $finish;
  end

  // Receiver: stall for a random time before taking each result
  initial begin
    int w;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      w = $urandom_range(0, 3);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk iff out_tvalid);
    end
  end

  task automatic send_op(input kind_t kind, input logic [31:0] key,
                         input logic [31:0] size, input logic present);
    int w;
    w = $urandom_range(0, 3);
    if (w > 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {7'd0, present, size, key};
    @(posedge clk iff in_tready);
  endtask

  task automatic write_budget(input logic [39:0] value);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= ADDR_BUDGET;
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  initial begin
    int n;
    kind_t k;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: zero budget, missing object, zero size, full table, pins
    send_op(K_ADMIT, 32'h5, 32'd10, 1'b1);
    send_op(K_ADMIT, 32'h5, 32'd10, 1'b0);
    send_op(K_ADMIT, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_op(K_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_op(K_LOOKUP, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_op(K_UNPIN, 32'h77, 32'd0, 1'b0);
    send_op(kind_t'(3'd7), 32'h1, 32'd1, 1'b1);
    write_budget(40'hFF_FFFF_FFFF);
    for (int i = 0; i < 18; i++) send_op(K_ADMIT, i, 32'hFFFF_FFFF, 1'b1);
    send_op(K_ADMIT, 32'd17, 32'd3, 1'b1);
    for (int i = 0; i < 17; i++) send_op(K_PIN, i, 32'd0, 1'b0);
    send_op(K_ADMIT, 32'd40, 32'd1, 1'b1);
    for (int i = 0; i < 260; i++) send_op(K_PIN, 32'd0, 32'd0, 1'b0);
    send_op(K_UNPIN, 32'd0, 32'd0, 1'b0);
    send_op(K_CLEAR, 32'd0, 32'd0, 1'b0);

    // Random phases over several budgets
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_budget(40'd1000);
        1: write_budget(40'd0);
        2: write_budget(40'hFF_FFFF_FFFF);
        3: write_budget({8'd0, 32'($urandom)});
        default: write_budget(40'd300);
      endcase
      for (n = 0; n < 220; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5:            k = K_LOOKUP;
          6, 7, 8, 9, 10, 11, 12, 13:  k = K_ADMIT;
          14, 15:                      k = K_PIN;
          16, 17:                      k = K_UNPIN;
          18:                          k = ($urandom_range(0, 3) == 0) ? K_CLEAR : K_PIN;
          default:                     k = kind_t'($urandom_range(5, 7));
        endcase
        send_op(k, pick_key(), pick_size(), $urandom_range(0, 9) != 0);
      end
    end
    in_tvalid <= 0;

    // Drain
    n = 0;
    while (pending != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_byte_budget_lru_cache_with_pins OK");
    else
      $display("tb_byte_budget_lru_cache_with_pins NOT OK");
    $finish;
  end
endmodule
